// File: design/flmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flmc_pkg;

   localparam int BUTTON_COMBOS_DEFAULT = 9;
   localparam int THRESH_COUNT = 8;
   localparam int THRESH_W = 8;

   localparam int CUR_W = 16;
   localparam int SECS_W = 16;
   localparam int SETTLE_W = 8;
   localparam int LEVEL_W = 8;
   localparam int CHOICE_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = THRESH_COUNT * THRESH_W;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   // event kinds
   typedef enum logic [1:0] {
      OP_REPORT = 2'd0,
      OP_BUTTON = 2'd1,
      OP_SECOND = 2'd2,
      OP_SETTLE = 2'd3
   } op_type;

   // drive codes
   typedef logic [1:0] drive_type;
   localparam drive_type DRIVE_OFF  = 2'd0;
   localparam drive_type DRIVE_LOW  = 2'd1;
   localparam drive_type DRIVE_HIGH = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_HIGH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_TIMEOUT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAN_TIMEOUT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLDS   = 3'd4;

   typedef struct packed {
      logic [CUR_W-1:0]      current_high_level;
      logic [SECS_W-1:0]     auto_timeout_secs;
      logic [SECS_W-1:0]     manual_timeout_secs;
      logic [SETTLE_W-1:0]   settle_ticks;
      logic [CSR_DATA_W-1:0] button_thresholds;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] button_level;
      logic [CUR_W-1:0]   sensor_current;
      op_type             op;
   } item_type;

   typedef struct packed {
      logic      light_in_auto;
      logic      fan_in_auto;
      drive_type light_drive;
      drive_type fan_drive;
   } result_type;

   // fan part of a button combination: auto, high, low by thirds
   function automatic drive_type combo_fan(input logic [CHOICE_W-1:0] pick);
      drive_type d;
      unique case (pick)
         4'd3, 4'd4, 4'd5: d = DRIVE_HIGH;
         4'd6, 4'd7, 4'd8: d = DRIVE_LOW;
         default:          d = DRIVE_OFF;
      endcase
      return d;
   endfunction

   // light part of a button combination: auto, high, low in turn
   function automatic drive_type combo_light(input logic [CHOICE_W-1:0] pick);
      drive_type d;
      unique case (pick)
         4'd1, 4'd4, 4'd7: d = DRIVE_HIGH;
         4'd2, 4'd5, 4'd8: d = DRIVE_LOW;
         default:          d = DRIVE_OFF;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// File: design/flmc_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module flmc_decode
   import flmc_pkg::*;
#(
   parameter int BUTTON_COMBOS = BUTTON_COMBOS_DEFAULT
) (
   input  wire logic [LEVEL_W-1:0]    sample,
   input  wire logic [CSR_DATA_W-1:0] thresholds,
   output logic      [CHOICE_W-1:0]   pick
);

   // first threshold below the sample wins, else the last combination
   always_comb begin
      logic found;
      found = 1'b0;
      pick  = CHOICE_W'(BUTTON_COMBOS - 1);
      for (int i = 0; i < THRESH_COUNT; i++) begin
         if (!found && (i < BUTTON_COMBOS - 1) &&
             (sample > thresholds[i*THRESH_W +: THRESH_W])) begin
            found = 1'b1;
            pick  = CHOICE_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// File: design/flmc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module flmc_core
   import flmc_pkg::*;
#(
   parameter int BUTTON_COMBOS = BUTTON_COMBOS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output result_type      result
);

   typedef enum logic [1:0] {
      PH_PROCESSED = 2'd0,
      PH_CHANGING  = 2'd1,
      PH_CHANGED   = 2'd2
   } phase_type;

   drive_type             fan_present_ff, fan_present_in;
   drive_type             fan_target_ff, fan_target_in;
   logic                  fan_auto_ff, fan_auto_in;
   drive_type             light_present_ff, light_present_in;
   logic                  light_auto_ff, light_auto_in;
   logic [SECS_W-1:0]     fan_timer_ff, fan_timer_in;
   logic [SECS_W-1:0]     light_timer_ff, light_timer_in;
   logic [SETTLE_W-1:0]   settle_ff, settle_in;
   logic [LEVEL_W-1:0]    last_sample_ff, last_sample_in;
   phase_type             phase_ff, phase_in;
   logic [CHOICE_W-1:0]   choice_ff, choice_in;
   logic [CHOICE_W-1:0]   pick;
   logic [LEVEL_W-1:0]    decode_sample;

   // a button item always leaves its own level as the last sample
   assign decode_sample = (item.op == OP_BUTTON) ? item.button_level : last_sample_ff;

   flmc_decode #(
      .BUTTON_COMBOS (BUTTON_COMBOS)
   ) u_decode (
      .sample     (decode_sample),
      .thresholds (cfg.button_thresholds),
      .pick       (pick)
   );

   always_comb begin
      fan_present_in   = fan_present_ff;
      fan_target_in    = fan_target_ff;
      fan_auto_in      = fan_auto_ff;
      light_present_in = light_present_ff;
      light_auto_in    = light_auto_ff;
      fan_timer_in     = fan_timer_ff;
      light_timer_in   = light_timer_ff;
      settle_in        = settle_ff;
      last_sample_in   = last_sample_ff;
      phase_in         = phase_ff;
      choice_in        = choice_ff;

      // apply the event
      unique case (item.op)
         OP_REPORT: begin
            fan_timer_in   = cfg.auto_timeout_secs;
            light_timer_in = cfg.auto_timeout_secs;
            if (fan_auto_ff) begin
               fan_target_in = (item.sensor_current >= cfg.current_high_level) ?
                               DRIVE_HIGH : DRIVE_LOW;
            end
            if (light_auto_ff) begin
               light_present_in = DRIVE_LOW;
            end
         end
         OP_BUTTON: begin
            if (item.button_level != last_sample_ff) begin
               phase_in       = PH_CHANGING;
               last_sample_in = item.button_level;
            end else if (phase_ff == PH_CHANGING) begin
               phase_in = PH_CHANGED;
            end
         end
         OP_SECOND: begin
            if (fan_timer_ff != '0) fan_timer_in = fan_timer_ff - 1'b1;
            if (light_timer_ff != '0) light_timer_in = light_timer_ff - 1'b1;
         end
         OP_SETTLE: begin
            if (settle_ff != '0) settle_in = settle_ff - 1'b1;
         end
         default: begin
         end
      endcase

      // timeouts
      if (fan_timer_in == '0) begin
         fan_target_in = DRIVE_OFF;
         fan_auto_in   = 1'b1;
      end
      if (light_timer_in == '0) begin
         light_present_in = DRIVE_OFF;
         light_auto_in    = 1'b1;
      end

      // stable button decode
      if (phase_in == PH_CHANGED) begin
         phase_in = PH_PROCESSED;
         if (pick != choice_ff) begin
            fan_target_in    = combo_fan(pick);
            light_present_in = combo_light(pick);
            fan_auto_in      = (combo_fan(pick) == DRIVE_OFF);
            light_auto_in    = (combo_light(pick) == DRIVE_OFF);
            if (combo_fan(pick) != DRIVE_OFF) fan_timer_in = cfg.manual_timeout_secs;
            if (combo_light(pick) != DRIVE_OFF) light_timer_in = cfg.manual_timeout_secs;
            choice_in = pick;
         end
      end

      // fan speed change always passes through off
      if (fan_present_ff != fan_target_in && settle_in == '0) begin
         if (fan_present_ff == DRIVE_OFF) begin
            fan_present_in = fan_target_in;
         end else begin
            fan_present_in = DRIVE_OFF;
            if (fan_target_in != DRIVE_OFF) settle_in = cfg.settle_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fan_present_ff   <= DRIVE_OFF;
         fan_target_ff    <= DRIVE_OFF;
         fan_auto_ff      <= 1'b1;
         light_present_ff <= DRIVE_OFF;
         light_auto_ff    <= 1'b1;
         fan_timer_ff     <= '0;
         light_timer_ff   <= '0;
         settle_ff        <= '0;
         last_sample_ff   <= '0;
         phase_ff         <= PH_PROCESSED;
         choice_ff        <= '0;
      end else if (step) begin
         fan_present_ff   <= fan_present_in;
         fan_target_ff    <= fan_target_in;
         fan_auto_ff      <= fan_auto_in;
         light_present_ff <= light_present_in;
         light_auto_ff    <= light_auto_in;
         fan_timer_ff     <= fan_timer_in;
         light_timer_ff   <= light_timer_in;
         settle_ff        <= settle_in;
         last_sample_ff   <= last_sample_in;
         phase_ff         <= phase_in;
         choice_ff        <= choice_in;
      end
   end

   assign result.fan_drive     = fan_present_in;
   assign result.light_drive   = light_present_in;
   assign result.fan_in_auto   = fan_auto_in;
   assign result.light_in_auto = light_auto_in;

endmodule

`default_nettype wire

// File: design/fan_light_mode_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------
// req      | in        | req_tvalid/tready    | op, sensor_current, button_level
// rsp      | out       | rsp_tvalid/tready    | fan_drive, light_drive, auto flags
// csr      | in        | csr_we (no wait)     | csr_index, csr_wdata
//
// one item per cycle sustained while rsp_tready stays high; an item's result passes from
// the input register through one evaluation pass into the result register
// the rate is set by the single evaluation pass that updates all mode state
// reset is synchronous: config, timers and valid flags zero, both outputs off and in auto
// a stalled result holds in the result register while one more item waits in
// the input register; req_tready drops only when both are full and the result
// is not being taken

module fan_light_mode_controller
   import flmc_pkg::*;
#(
   parameter int BUTTON_COMBOS = BUTTON_COMBOS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // op [1:0], sensor_current [17:2], button_level [25:18], zero [31:26]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // fan_drive [1:0], light_drive [3:2], fan_in_auto [4], light_in_auto [5], zero [7:6]
   output logic      [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result_ff;
   logic       rsp_valid_ff;
   result_type result_in;
   logic       step;

   // the held item is evaluated once the result register is free
   assign step       = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || step;

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CURRENT_HIGH: cfg_ff.current_high_level  <= csr_wdata[CUR_W-1:0];
            CSR_AUTO_TIMEOUT: cfg_ff.auto_timeout_secs   <= csr_wdata[SECS_W-1:0];
            CSR_MAN_TIMEOUT:  cfg_ff.manual_timeout_secs <= csr_wdata[SECS_W-1:0];
            CSR_SETTLE_TICKS: cfg_ff.settle_ticks        <= csr_wdata[SETTLE_W-1:0];
            CSR_THRESHOLDS:   cfg_ff.button_thresholds   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_tdata[$bits(item_type)-1:0];
      end
   end

   flmc_core #(
      .BUTTON_COMBOS (BUTTON_COMBOS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(result_type))'(0), result_ff};

endmodule

`default_nettype wire
